FILE: rtl/cstsup_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the month-length table for the seconds calendar supervisor.
// No dependencies; the files that use this package refer to it by scoped names.
package cstsup_pkg;

  // Millisecond counters saturate at the top of this width
  localparam int unsigned MsW = 16;
  localparam logic [MsW-1:0] FallbackRestartMs = 16'd500;

  // Register reset values
  localparam logic [6:0]  TickMsRst      = 7'd5;
  localparam logic [10:0] PulseGapMsRst  = 11'd750;
  localparam logic [10:0] ReleaseMsRst   = 11'd500;
  localparam logic [11:0] FallbackMsRst  = 12'd1500;

  // Calendar limits and marker periods
  localparam logic [5:0] SecMax         = 6'd59;
  localparam logic [5:0] MinMax         = 6'd59;
  localparam logic [4:0] HourMax        = 5'd23;
  localparam logic [3:0] MonthMax       = 4'd12;
  localparam logic [3:0] MonthFeb       = 4'd2;
  localparam logic [6:0] YearMax        = 7'd99;
  localparam logic [5:0] ReleaseSec     = 6'd30;
  localparam logic [2:0] FiveSecCount   = 3'd5;
  localparam logic [3:0] TenMinCount    = 4'd10;
  localparam logic [4:0] ThirtyMinCount = 5'd30;
  localparam logic [4:0] LeapFebDays    = 5'd29;

  // Register map, one 32-bit word per register
  localparam int unsigned AddrW = 4;
  typedef enum logic [1:0] {
    RegTickMs     = 2'd0,
    RegPulseGapMs = 2'd1,
    RegReleaseMs  = 2'd2,
    RegFallbackMs = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [6:0]  tick_ms;
    logic [10:0] pulse_gap_ms;
    logic [10:0] release_ms;
    logic [11:0] fallback_ms;
  } cfg_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } date_t;

  localparam date_t DateRst = '{year: 7'd0, month: 4'd1, day: 5'd1,
                                hour: 5'd0, minute: 6'd0, second: 6'd0};

  // Sub-counters behind the five-second, ten-minute and thirty-minute markers
  typedef struct packed {
    logic [2:0] five;
    logic [3:0] ten;
    logic [4:0] thirty;
  } cnt_t;

  // Pending / released marker set
  typedef struct packed {
    logic thirty;
    logic ten;
    logic minute;
    logic five;
    logic sec;
  } marks_t;

  typedef struct packed {
    date_t  date;
    marks_t released;
    logic   min_roll;
  } res_t;

  localparam logic [4:0] MonthDays [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  // Month length, February gets 29 days when the year is a multiple of four
  function automatic logic [4:0] days_in_month(input logic [6:0] year,
                                               input logic [3:0] month);
    logic [4:0] d;
    d = MonthDays[month];
    if (month == MonthFeb && year[1:0] == 2'b00) d = LeapFebDays;
    return d;
  endfunction

endpackage

FILE: rtl/cstsup_cfg.sv
`timescale 1ns / 1ps
// APB-style register file holding the four timing registers.
// Depends on cstsup_pkg for the register map and the cfg_t struct.
module cstsup_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [cstsup_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]                  pwdata_i,
  output logic [31:0]                  prdata_o,
  output cstsup_pkg::cfg_t             cfg_o
);

  cstsup_pkg::cfg_t      cfg_q, cfg_d;
  cstsup_pkg::reg_idx_e  idx;
  logic                  wr_en;

  assign idx   = cstsup_pkg::reg_idx_e'(paddr_i[3:2]);
  assign wr_en = psel_i && penable_i && pwrite_i;

  // Decode the write word into the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        cstsup_pkg::RegTickMs:     cfg_d.tick_ms      = pwdata_i[6:0];
        cstsup_pkg::RegPulseGapMs: cfg_d.pulse_gap_ms = pwdata_i[10:0];
        cstsup_pkg::RegReleaseMs:  cfg_d.release_ms   = pwdata_i[10:0];
        cstsup_pkg::RegFallbackMs: cfg_d.fallback_ms  = pwdata_i[11:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{tick_ms:      cstsup_pkg::TickMsRst,
                 pulse_gap_ms: cstsup_pkg::PulseGapMsRst,
                 release_ms:   cstsup_pkg::ReleaseMsRst,
                 fallback_ms:  cstsup_pkg::FallbackMsRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back, zero-extended
  always_comb begin
    case (idx)
      cstsup_pkg::RegTickMs:     prdata_o = {25'd0, cfg_q.tick_ms};
      cstsup_pkg::RegPulseGapMs: prdata_o = {21'd0, cfg_q.pulse_gap_ms};
      cstsup_pkg::RegReleaseMs:  prdata_o = {21'd0, cfg_q.release_ms};
      cstsup_pkg::RegFallbackMs: prdata_o = {20'd0, cfg_q.fallback_ms};
      default:                   prdata_o = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/cstsup_cal.sv
`timescale 1ns / 1ps
// One-second calendar advance with carry chain and marker arming.
// Depends on cstsup_pkg for the date, counter and marker structs.
module cstsup_cal (
  input  cstsup_pkg::date_t  date_i,
  input  cstsup_pkg::cnt_t   cnt_i,
  output cstsup_pkg::date_t  date_o,
  output cstsup_pkg::cnt_t   cnt_o,
  output cstsup_pkg::marks_t arm_o,
  output logic               min_roll_o
);

  logic       sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
  logic [2:0] five_n;
  logic [3:0] ten_n;
  logic [4:0] thirty_n;

  // Carry chain from seconds up to the year
  assign sec_wrap   = (date_i.second >= cstsup_pkg::SecMax);
  assign min_wrap   = sec_wrap && (date_i.minute >= cstsup_pkg::MinMax);
  assign hour_wrap  = min_wrap && (date_i.hour >= cstsup_pkg::HourMax);
  assign day_wrap   = hour_wrap &&
                      (date_i.day >= cstsup_pkg::days_in_month(date_i.year, date_i.month));
  assign month_wrap = day_wrap && (date_i.month >= cstsup_pkg::MonthMax);

  always_comb begin
    date_o = date_i;
    date_o.second = sec_wrap ? 6'd0 : date_i.second + 6'd1;
    if (sec_wrap)  date_o.minute = min_wrap ? 6'd0 : date_i.minute + 6'd1;
    if (min_wrap)  date_o.hour   = hour_wrap ? 5'd0 : date_i.hour + 5'd1;
    if (hour_wrap) date_o.day    = day_wrap ? 5'd1 : date_i.day + 5'd1;
    if (day_wrap)  date_o.month  = month_wrap ? 4'd1 : date_i.month + 4'd1;
    if (month_wrap) begin
      date_o.year = (date_i.year >= cstsup_pkg::YearMax) ? 7'd0 : date_i.year + 7'd1;
    end
  end

  // Marker sub-counters; minute counters step only on a minute roll
  assign five_n   = cnt_i.five + 3'd1;
  assign ten_n    = cnt_i.ten + 4'd1;
  assign thirty_n = cnt_i.thirty + 5'd1;

  always_comb begin
    arm_o        = '0;
    arm_o.sec    = 1'b1;
    cnt_o        = cnt_i;
    if (five_n >= cstsup_pkg::FiveSecCount) begin
      cnt_o.five = 3'd0;
      arm_o.five = 1'b1;
    end else begin
      cnt_o.five = five_n;
    end
    if (sec_wrap) begin
      arm_o.minute = 1'b1;
      if (ten_n >= cstsup_pkg::TenMinCount) begin
        cnt_o.ten  = 4'd0;
        arm_o.ten  = 1'b1;
      end else begin
        cnt_o.ten  = ten_n;
      end
      if (thirty_n >= cstsup_pkg::ThirtyMinCount) begin
        cnt_o.thirty = 5'd0;
        arm_o.thirty = 1'b1;
      end else begin
        cnt_o.thirty = thirty_n;
      end
    end
  end

  assign min_roll_o = sec_wrap;

endmodule

FILE: rtl/cstsup_core.sv
`timescale 1ns / 1ps
// Supervisor state: millisecond counters, pulse qualification, fallback and marker release.
// Depends on cstsup_pkg and instantiates cstsup_cal for the calendar advance.
module cstsup_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cstsup_pkg::cfg_t   cfg_i,
  input  logic               step_i,
  input  logic               op_i,
  input  logic               pd_i,
  output cstsup_pkg::res_t   res_o
);

  localparam int unsigned MsW = cstsup_pkg::MsW;

  cstsup_pkg::date_t  date_q, date_d, date_adv;
  cstsup_pkg::cnt_t   cnt_q, cnt_d, cnt_adv;
  cstsup_pkg::marks_t pend_q, pend_d, arm, released;
  logic [MsW-1:0]     soft_q, soft_d, soft_sat;
  logic [MsW-1:0]     pulse_q, pulse_d, pulse_sat;
  logic [MsW:0]       soft_sum, pulse_sum;
  logic               seen_q, seen_d;
  logic               do_adv, cal_roll;

  cstsup_cal u_cal (
    .date_i     (date_q),
    .cnt_i      (cnt_q),
    .date_o     (date_adv),
    .cnt_o      (cnt_adv),
    .arm_o      (arm),
    .min_roll_o (cal_roll)
  );

  // Saturating millisecond adds
  assign soft_sum  = {1'b0, soft_q} + {{(MsW - 6){1'b0}}, cfg_i.tick_ms};
  assign pulse_sum = {1'b0, pulse_q} + {{(MsW - 6){1'b0}}, cfg_i.tick_ms};
  assign soft_sat  = soft_sum[MsW] ? '1 : soft_sum[MsW-1:0];
  assign pulse_sat = pulse_sum[MsW] ? '1 : pulse_sum[MsW-1:0];

  // Decide release and advance for the word in flight
  always_comb begin
    soft_d   = soft_q;
    pulse_d  = pulse_q;
    seen_d   = seen_q;
    released = '0;
    do_adv   = 1'b0;
    if (!op_i) begin
      soft_d  = soft_sat;
      pulse_d = pulse_sat;
      if (!pd_i) begin
        if (soft_sat > {5'd0, cfg_i.release_ms}) begin
          released.sec  = pend_q.sec;
          released.five = pend_q.five;
          if (date_q.second > cstsup_pkg::ReleaseSec) begin
            released.minute = pend_q.minute;
            released.ten    = pend_q.ten;
            released.thirty = pend_q.thirty;
          end
        end
        if (soft_sat >= {4'd0, cfg_i.fallback_ms}) begin
          soft_d = cstsup_pkg::FallbackRestartMs;
          do_adv = 1'b1;
        end
      end
    end else if (!seen_q) begin
      soft_d = '0;
      seen_d = 1'b1;
      do_adv = 1'b1;
    end else if (pulse_q > {5'd0, cfg_i.pulse_gap_ms}) begin
      soft_d  = '0;
      pulse_d = '0;
      do_adv  = 1'b1;
    end
  end

  assign pend_d = (pend_q & ~released) | (do_adv ? arm : '0);
  assign date_d = do_adv ? date_adv : date_q;
  assign cnt_d  = do_adv ? cnt_adv : cnt_q;

  // Hold state between words, update on each processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_q  <= cstsup_pkg::DateRst;
      cnt_q   <= '0;
      pend_q  <= '0;
      soft_q  <= '0;
      pulse_q <= '0;
      seen_q  <= 1'b0;
    end else if (step_i) begin
      date_q  <= date_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      soft_q  <= soft_d;
      pulse_q <= pulse_d;
      seen_q  <= seen_d;
    end
  end

  assign res_o = '{date: date_d, released: released, min_roll: do_adv && cal_roll};

endmodule

FILE: rtl/calendar_second_tick_supervisor_top.sv
`timescale 1ns / 1ps
// Top level of the seconds calendar supervisor: stream ports, APB port and pipeline.
// Depends on cstsup_pkg, cstsup_cfg and cstsup_core.

// The block takes one word per clock, back to back, while the result side is not
// stalled, and returns exactly one result word for each. A word passes an input
// register and then a result register; the whole update (millisecond counters, pulse
// check, marker release and the one-second carry through the calendar) is
// combinational logic between those registers, and the state loop closes through it.
// Back-pressure on the result side stalls both stages together; while the result
// register is full and not taken the input register still accepts one word if it is
// empty. There is no clearing pass after reset. Register writes belong in idle periods.
module calendar_second_tick_supervisor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] power_down, [7:1] zero
  input  logic [0:0]  s_axis_tuser,   // [0] op: 0 millisecond tick, 1 second pulse
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // year, month, day, hour, minute, second,
                                      // one_second, five_second, one_minute,
                                      // minute_plus_half, ten_minute, thirty_minute,
                                      // zero pad (lowest bit first)
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cstsup_pkg::cfg_t cfg;
  cstsup_pkg::res_t res, out_q;
  logic             in_vld_q, in_op_q, in_pd_q;
  logic             out_vld_q;
  logic             adv, step;

  assign pready = 1'b1;

  cstsup_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // Pipeline advances when the result register is empty or being drained
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;
  assign step          = in_vld_q && adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q <= s_axis_tuser[0];
      in_pd_q <= s_axis_tdata[0];
    end
  end

  cstsup_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .op_i   (in_op_q),
    .pd_i   (in_pd_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0,
                          out_q.released.thirty,
                          out_q.released.ten,
                          out_q.released.minute,
                          out_q.min_roll,
                          out_q.released.five,
                          out_q.released.sec,
                          out_q.date.second,
                          out_q.date.minute,
                          out_q.date.hour,
                          out_q.date.day,
                          out_q.date.month,
                          out_q.date.year};

endmodule

FILE: rtl/cstsup_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the seconds calendar supervisor, bound to the top level.
// Depends only on the top level's result stream ports.
module cstsup_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic [5:0] second;
  logic       one_second, five_second, one_minute, minute_plus_half;
  logic       ten_minute, thirty_minute;

  assign second           = m_axis_tdata[32:27];
  assign one_second       = m_axis_tdata[33];
  assign five_second      = m_axis_tdata[34];
  assign one_minute       = m_axis_tdata[35];
  assign minute_plus_half = m_axis_tdata[36];
  assign ten_minute       = m_axis_tdata[37];
  assign thirty_minute    = m_axis_tdata[38];

  // A stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // A minute roll always lands on second zero
  a_roll_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && one_minute |-> second == 6'd0)
    else $error("minute roll with nonzero second");

  // Five-second marker is armed with the one-second marker and released with it
  a_five_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && five_second |-> one_second)
    else $error("five-second marker without one-second marker");

  // Ten- and thirty-minute markers always come with the minute marker
  a_min_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (ten_minute || thirty_minute) |-> minute_plus_half)
    else $error("minute-group marker without minute marker");

endmodule

bind calendar_second_tick_supervisor_top cstsup_chk u_cstsup_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/cstsup_tb_pkg.sv
`timescale 1ns / 1ps
// Operation codes shared by the calendar supervisor bench and its scoreboard.
// No dependencies.
package cstsup_tb_pkg;

  // Kind of input word, carried in tuser
  typedef enum logic {
    OpTick  = 1'b0,
    OpPulse = 1'b1
  } op_e;

endpackage

FILE: bench/cstsup_calendar_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the seconds calendar supervisor: follows the register port and both
// streams, predicts each result word and compares it field by field.
// Depends on cstsup_pkg (register indexes, calendar types) and cstsup_tb_pkg.
module cstsup_calendar_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] power_down, [7:1] zero
  input  logic [0:0]  s_axis_tuser,   // [0] op
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // calendar fields, markers, pad (lowest bit first)
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned errors_o,
  output int unsigned waiting_o
);

  localparam logic [15:0] MsCeil    = 16'hFFFF;
  localparam logic [15:0] RestartMs = 16'd500;

  // Result word laid out as on the bus, year in the lowest bits
  typedef struct packed {
    logic       thirty_minute;
    logic       ten_minute;
    logic       minute_plus_half;
    logic       one_minute;
    logic       five_second;
    logic       one_second;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } cal_word_t;

  // Register copies
  logic [6:0]  tick_step;
  logic [10:0] gap_min;
  logic [10:0] release_after;
  logic [11:0] fallback_at;

  // Calendar and timing state
  cstsup_pkg::date_t  cal;
  cstsup_pkg::marks_t held;
  logic [15:0] soft_count;
  logic [15:0] pulse_count;
  logic        pulse_armed;
  logic [2:0]  five_cnt;
  logic [3:0]  ten_cnt;
  logic [4:0]  thirty_cnt;

  cal_word_t   due_q[$];
  int unsigned errors = 0;

  function automatic logic [15:0] ms_add(logic [15:0] a, logic [6:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {10'd0, b};
    return s[16] ? MsCeil : s[15:0];
  endfunction

  function automatic logic [4:0] month_length(logic [6:0] yr, logic [3:0] mo);
    case (mo)
      4'd2: begin
        return (yr % 4 == 0) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        return 5'd30;
      end
      default: begin
        return 5'd31;
      end
    endcase
  endfunction

  // Step the calendar by one second and arm markers; return the minute carry
  function automatic logic advance_second();
    logic roll;
    roll = 1'b0;
    held.sec = 1'b1;
    five_cnt = five_cnt + 3'd1;
    if (cal.second < 6'd59) begin
      cal.second = cal.second + 6'd1;
    end else begin
      cal.second = '0;
      roll = 1'b1;
      held.minute = 1'b1;
      ten_cnt = ten_cnt + 4'd1;
      thirty_cnt = thirty_cnt + 5'd1;
      if (cal.minute < 6'd59) begin
        cal.minute = cal.minute + 6'd1;
      end else begin
        cal.minute = '0;
        if (cal.hour < 5'd23) begin
          cal.hour = cal.hour + 5'd1;
        end else begin
          cal.hour = '0;
          if (cal.day < month_length(cal.year, cal.month)) begin
            cal.day = cal.day + 5'd1;
          end else begin
            cal.day = 5'd1;
            if (cal.month < 4'd12) begin
              cal.month = cal.month + 4'd1;
            end else begin
              cal.month = 4'd1;
              cal.year = (cal.year >= 7'd99) ? 7'd0 : cal.year + 7'd1;
            end
          end
        end
      end
      if (ten_cnt >= 4'd10) begin
        ten_cnt = '0;
        held.ten = 1'b1;
      end
      if (thirty_cnt >= 5'd30) begin
        thirty_cnt = '0;
        held.thirty = 1'b1;
      end
    end
    if (five_cnt >= 3'd5) begin
      five_cnt = '0;
      held.five = 1'b1;
    end
    return roll;
  endfunction

  // Apply one input word to the state and build the result it must produce
  function automatic cal_word_t next_result(logic is_pulse, logic pd);
    cstsup_pkg::marks_t out_marks;
    cal_word_t r;
    logic roll;
    out_marks = '0;
    roll = 1'b0;
    if (!is_pulse) begin
      soft_count = ms_add(soft_count, tick_step);
      pulse_count = ms_add(pulse_count, tick_step);
      if (!pd) begin
        // release markers first, minute-type ones only past second 30
        if (soft_count > {5'd0, release_after}) begin
          out_marks.sec = held.sec;
          out_marks.five = held.five;
          if (cal.second > 6'd30) begin
            out_marks.minute = held.minute;
            out_marks.ten = held.ten;
            out_marks.thirty = held.thirty;
          end
          held = held & ~out_marks;
        end
        // software fallback when pulses have stopped
        if (soft_count >= {4'd0, fallback_at}) begin
          soft_count = RestartMs;
          roll = advance_second();
        end
      end
    end else if (!pulse_armed) begin
      soft_count = '0;
      pulse_armed = 1'b1;
      roll = advance_second();
    end else if (pulse_count > {5'd0, gap_min}) begin
      soft_count = '0;
      pulse_count = '0;
      roll = advance_second();
    end
    r.year = cal.year;
    r.month = cal.month;
    r.day = cal.day;
    r.hour = cal.hour;
    r.minute = cal.minute;
    r.second = cal.second;
    r.one_second = out_marks.sec;
    r.five_second = out_marks.five;
    r.one_minute = roll;
    r.minute_plus_half = out_marks.minute;
    r.ten_minute = out_marks.ten;
    r.thirty_minute = out_marks.thirty;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors = errors + 1;
    end
  endtask

  // Follow config writes, compare result words, predict accepted input words
  always @(posedge clk_i or negedge rst_ni) begin
    cal_word_t got;
    cal_word_t want;
    if (!rst_ni) begin
      tick_step = 7'd5;
      gap_min = 11'd750;
      release_after = 11'd500;
      fallback_at = 12'd1500;
      cal.year = 7'd0;
      cal.month = 4'd1;
      cal.day = 5'd1;
      cal.hour = 5'd0;
      cal.minute = 6'd0;
      cal.second = 6'd0;
      held = '0;
      soft_count = '0;
      pulse_count = '0;
      pulse_armed = 1'b0;
      five_cnt = '0;
      ten_cnt = '0;
      thirty_cnt = '0;
      due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cstsup_pkg::reg_idx_e'(paddr[3:2]))
          cstsup_pkg::RegTickMs:     tick_step = pwdata[6:0];
          cstsup_pkg::RegPulseGapMs: gap_min = pwdata[10:0];
          cstsup_pkg::RegReleaseMs:  release_after = pwdata[10:0];
          cstsup_pkg::RegFallbackMs: fallback_at = pwdata[11:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[38:0];
        if (due_q.size() == 0) begin
          $error("result word %h arrived with nothing expected", m_axis_tdata);
          errors = errors + 1;
        end else begin
          want = due_q.pop_front();
          check_field("year", want.year, got.year);
          check_field("month", want.month, got.month);
          check_field("day", want.day, got.day);
          check_field("hour", want.hour, got.hour);
          check_field("minute", want.minute, got.minute);
          check_field("second", want.second, got.second);
          check_field("one_second", want.one_second, got.one_second);
          check_field("five_second", want.five_second, got.five_second);
          check_field("one_minute", want.one_minute, got.one_minute);
          check_field("minute_plus_half", want.minute_plus_half, got.minute_plus_half);
          check_field("ten_minute", want.ten_minute, got.ten_minute);
          check_field("thirty_minute", want.thirty_minute, got.thirty_minute);
          check_field("pad", 32'd0, m_axis_tdata[39]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        due_q.push_back(next_result(s_axis_tuser[0] == cstsup_tb_pkg::OpPulse,
                                    s_axis_tdata[0]));
      end
    end
    errors_o = errors;
    waiting_o = due_q.size();
  end

endmodule

FILE: bench/calendar_second_tick_supervisor_top_tb.sv
`timescale 1ns / 1ps
// Bench top for the seconds calendar supervisor: clock, reset, register writes and
// stream stimulus with random idling; the scoreboard module does all checking.
// Depends on cstsup_pkg, cstsup_tb_pkg, cstsup_calendar_checker and the block itself.
module calendar_second_tick_supervisor_top_tb;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandomWords = 950;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] power_down, [7:1] zero
  logic [0:0]  s_axis_tuser = '0;   // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // calendar fields, markers, pad (lowest bit first)
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned errors;
  int unsigned waiting;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned hold_left = 0;
  bit          idle_on = 1'b0;

  calendar_second_tick_supervisor_top dut (.*);

  cstsup_calendar_checker checker_i (
    .errors_o (errors),
    .waiting_o(waiting),
    .*
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // End the run if it hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stall the result side in bursts of random length
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(cstsup_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] step, logic [31:0] gap, logic [31:0] rel,
                           logic [31:0] fall);
    write_reg(cstsup_pkg::RegTickMs, step);
    write_reg(cstsup_pkg::RegPulseGapMs, gap);
    write_reg(cstsup_pkg::RegReleaseMs, rel);
    write_reg(cstsup_pkg::RegFallbackMs, fall);
  endtask

  // Present one word, idling first now and then, and hold it until taken
  task automatic send_word(cstsup_tb_pkg::op_e op, logic pd);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, pd};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sent = sent + 1;
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (waiting != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick4(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                        logic [31:0] d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  // Fallback fires on nearly every tick, so the calendar runs fast
  task automatic run_fast(int unsigned n);
    int unsigned r;
    write_all($urandom_range(1, 100), $urandom_range(0, 300), $urandom_range(0, 700),
              $urandom_range(0, 600));
    repeat (n) begin
      r = $urandom_range(0, 19);
      if (r < 18) send_word(cstsup_tb_pkg::OpTick, 1'b0);
      else if (r == 18) send_word(cstsup_tb_pkg::OpPulse, 1'($urandom_range(0, 1)));
      else send_word(cstsup_tb_pkg::OpTick, 1'b1);
    end
  endtask

  // Tick runs ending in a pulse near the gap limit, some pulses too early
  task automatic run_pulses(int unsigned n);
    int unsigned step;
    int unsigned gap;
    int unsigned stop;
    step = $urandom_range(1, 20);
    gap = step * $urandom_range(0, 15);
    write_all(step, gap, $urandom_range(0, 400), $urandom_range(1500, 4095));
    stop = sent + n;
    while (sent < stop) begin
      repeat (gap / step + $urandom_range(0, 2)) begin
        send_word(cstsup_tb_pkg::OpTick, $urandom_range(0, 4) == 0);
        if ($urandom_range(0, 15) == 0) begin
          send_word(cstsup_tb_pkg::OpPulse, 1'($urandom_range(0, 1)));
        end
      end
      send_word(cstsup_tb_pkg::OpPulse, 1'($urandom_range(0, 1)));
    end
  endtask

  // Register extremes with an unshaped mix of words
  task automatic run_extremes(int unsigned n);
    write_all(pick4(0, 1, 100, 127), pick4(0, 1, 2000, 2047), pick4(0, 1, 2000, 2047),
              pick4(0, 1, 4000, 4095));
    repeat (n) begin
      send_word(cstsup_tb_pkg::op_e'($urandom_range(0, 2) == 0), 1'($urandom_range(0, 1)));
    end
  endtask

  // Powered-down ticks until both millisecond counters sit at their ceiling
  task automatic run_saturation();
    write_all(127, $urandom_range(0, 2047), $urandom_range(0, 2047), 4095);
    repeat (530) send_word(cstsup_tb_pkg::OpTick, 1'b1);
    send_word(cstsup_tb_pkg::OpTick, 1'b0);
    send_word(cstsup_tb_pkg::OpPulse, 1'b0);
    repeat (3) send_word(cstsup_tb_pkg::OpTick, 1'b0);
  endtask

  initial begin
    int unsigned goal;
    int unsigned kind;
    bit sat_done;
    sat_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: first pulse advances, later close pulses are ignored
    send_word(cstsup_tb_pkg::OpTick, 1'b0);
    send_word(cstsup_tb_pkg::OpTick, 1'b1);
    send_word(cstsup_tb_pkg::OpPulse, 1'b0);
    send_word(cstsup_tb_pkg::OpPulse, 1'b1);
    send_word(cstsup_tb_pkg::OpPulse, 1'b0);
    drain();

    // Instant fallback: release, power-down counting, pulse while powered down
    write_all(100, 0, 0, 1);
    send_word(cstsup_tb_pkg::OpTick, 1'b1);
    repeat (4) send_word(cstsup_tb_pkg::OpTick, 1'b0);
    send_word(cstsup_tb_pkg::OpPulse, 1'b1);
    send_word(cstsup_tb_pkg::OpPulse, 1'b0);
    send_word(cstsup_tb_pkg::OpTick, 1'b0);
    send_word(cstsup_tb_pkg::OpTick, 1'b1);
    drain();

    // Zero tick adds nothing; every limit at its field maximum
    write_all(0, 2047, 2047, 4095);
    send_word(cstsup_tb_pkg::OpTick, 1'b0);
    send_word(cstsup_tb_pkg::OpTick, 1'b0);
    send_word(cstsup_tb_pkg::OpPulse, 1'b0);
    drain();

    // Largest tick with a zero fallback
    write_all(127, 2000, 2000, 0);
    send_word(cstsup_tb_pkg::OpTick, 1'b0);
    send_word(cstsup_tb_pkg::OpTick, 1'b0);
    send_word(cstsup_tb_pkg::OpPulse, 1'b1);
    send_word(cstsup_tb_pkg::OpTick, 1'b1);
    drain();

    // Random phases, each after the block has gone idle; saturation counts toward goal
    goal = sent + RandomWords;
    while (sent < goal) begin
      idle_on <= (goal - sent > 120) && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (!sat_done && goal - sent < RandomWords - 100) begin
        sat_done = 1'b1;
        run_saturation();
      end else if (kind < 7) begin
        run_fast($urandom_range(20, 80));
      end else if (kind < 9) begin
        run_pulses($urandom_range(30, 80));
      end else begin
        run_extremes($urandom_range(20, 50));
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0 && waiting == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
